// ----- rtl/core/dtt_pkg.sv -----
// shared types and constants for the one-shot timer table
// no dependencies
`timescale 1ns / 1ps

package dtt_pkg;

  localparam int unsigned MAX_TASKS = 64;
  localparam int unsigned SLOT_W    = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TASK_W    = 16;
  localparam int unsigned DELAY_W   = 31;

  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  typedef enum logic [1:0] {
    KIND_SCHEDULED = 2'd0,
    KIND_FIRED     = 2'd1,
    KIND_FULL      = 2'd2,
    KIND_IDLE      = 2'd3
  } kind_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic              fired;
    logic [TASK_W-1:0] task_ref;
    logic [TIME_W-1:0] due;
  } entry_t;

endpackage

// ----- rtl/core/delayed_task_timer_table_core.sv -----
// top level of the one-shot timer table: sequencer, output register, used count
// depends on dtt_pkg, dtt_alu, dtt_table
`timescale 1ns / 1ps

// One-shot timer table with up to 64 entries filled in slot order. A schedule
// transaction (action 0) stores task id and due time now + delay, saturated at the
// 32-bit maximum, and returns one result; a full table returns kind 2. A tick
// transaction (action 1) scans the used slots and returns one kind-1 result per entry
// whose due time is strictly below now, marking it fired, with last on the final one;
// with nothing due it returns kind 3. The input stalls while a transaction is worked.
// A tick reads then compares each used slot in turn (S_READ, S_CMP), set by the
// single read port of the entry memory and the one shared add/compare unit that
// checks one entry at a time. Output stalls hold the sequencer. Entries need no clearing
// after reset.
module delayed_task_timer_table_core import dtt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [TASK_W-1:0]  task_id_i,
  input  logic [DELAY_W-1:0] delay_ms_i,
  input  logic [TIME_W-1:0]  now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [TASK_W-1:0]  fired_task_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCHED,
    S_READ,
    S_CMP
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   used_q;
  logic [CNT_W-1:0]   idx_q;
  logic [TASK_W-1:0]  id_q;
  logic [DELAY_W-1:0] delay_q;
  logic [TIME_W-1:0]  now_q;
  logic               have_pend_q;
  logic [TASK_W-1:0]  pend_task_q;
  logic [SLOT_W-1:0]  pend_slot_q;

  logic               out_valid_q;
  kind_e              kind_q;
  logic [TASK_W-1:0]  task_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               last_q;

  alu_op_e            alu_op;
  logic [TIME_W-1:0]  alu_a;
  logic [TIME_W-1:0]  alu_b;
  logic [TIME_W-1:0]  alu_sum;
  logic               alu_carry;

  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  entry_t             wr_data;
  logic               rd_en;
  entry_t             rd_data;

  logic               out_free;
  logic               full;
  logic               scan_end;
  logic               fire;
  logic               emit;
  kind_e              emit_kind;
  logic [TASK_W-1:0]  emit_task;
  logic [SLOT_W-1:0]  emit_slot;
  logic               emit_last;
  logic [TIME_W-1:0]  due_sat;

  dtt_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  dtt_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[SLOT_W-1:0]),
    .rd_data_o (rd_data)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (used_q >= CNT_W'(MAX_TASKS));
  assign scan_end = (idx_q == used_q);
  assign due_sat  = alu_carry ? {TIME_W{1'b1}} : alu_sum;
  // due < now exactly when due - now borrows
  assign fire     = !rd_data.fired && !alu_carry;

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = now_q;
    alu_b  = {1'b0, delay_q};
    if (state_q == S_CMP) begin
      alu_op = ALU_SUB;
      alu_a  = rd_data.due;
      alu_b  = now_q;
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_IDLE;
    emit_task = '0;
    emit_slot = '0;
    emit_last = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = idx_q[SLOT_W-1:0];
    wr_data   = rd_data;
    rd_en     = 1'b0;
    unique case (state_q)
      S_SCHED: begin
        emit = out_free;
        if (full) begin
          emit_kind = KIND_FULL;
        end else begin
          emit_kind = KIND_SCHEDULED;
          emit_task = id_q;
          emit_slot = used_q[SLOT_W-1:0];
          wr_en     = out_free;
          wr_addr   = used_q[SLOT_W-1:0];
          wr_data   = '{fired: 1'b0, task_ref: id_q, due: due_sat};
        end
      end
      S_READ: begin
        if (scan_end) begin
          emit = out_free;
          if (have_pend_q) begin
            emit_kind = KIND_FIRED;
            emit_task = pend_task_q;
            emit_slot = pend_slot_q;
          end
        end else begin
          rd_en = 1'b1;
        end
      end
      S_CMP: begin
        if (fire) begin
          emit      = have_pend_q && out_free;
          emit_kind = KIND_FIRED;
          emit_task = pend_task_q;
          emit_slot = pend_slot_q;
          emit_last = 1'b0;
          wr_en     = !have_pend_q || out_free;
          wr_data   = '{fired: 1'b1, task_ref: rd_data.task_ref, due: rd_data.due};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      idx_q       <= '0;
      have_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        kind_q      <= emit_kind;
        task_q      <= emit_task;
        slot_q      <= emit_slot;
        last_q      <= emit_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            id_q        <= task_id_i;
            delay_q     <= delay_ms_i;
            now_q       <= now_ms_i;
            idx_q       <= '0;
            have_pend_q <= 1'b0;
            state_q     <= (action_i == ACT_TICK) ? S_READ : S_SCHED;
          end
        end
        S_SCHED: begin
          if (out_free) begin
            if (!full) begin
              used_q <= used_q + CNT_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        S_READ: begin
          if (scan_end) begin
            if (out_free) begin
              state_q <= S_IDLE;
            end
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (!fire) begin
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= S_READ;
          end else if (wr_en) begin
            have_pend_q <= 1'b1;
            pend_task_q <= rd_data.task_ref;
            pend_slot_q <= idx_q[SLOT_W-1:0];
            idx_q       <= idx_q + CNT_W'(1);
            state_q     <= S_READ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign fired_task_o = task_q;
  assign slot_o       = slot_q;
  assign last_o       = last_q;

endmodule

// ----- rtl/core/dtt_alu.sv -----
// shared add / subtract unit for due time sums and expiry compares
// depends on dtt_pkg
`timescale 1ns / 1ps

module dtt_alu import dtt_pkg::*; (
  input  alu_op_e           op_i,
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  output logic [TIME_W-1:0] sum_o,
  output logic              carry_o
);

  logic [TIME_W-1:0] b_op;
  logic [TIME_W:0]   res;

  assign b_op = (op_i == ALU_SUB) ? ~b_i : b_i;
  assign res  = {1'b0, a_i} + {1'b0, b_op} + {{TIME_W{1'b0}}, (op_i == ALU_SUB)};

  assign sum_o   = res[TIME_W-1:0];
  assign carry_o = res[TIME_W];

endmodule

// ----- rtl/core/dtt_table.sv -----
// timer entry memory: one write port, one registered read port
// depends on dtt_pkg
`timescale 1ns / 1ps

module dtt_table import dtt_pkg::*; (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_addr_i,
  input  entry_t            wr_data_i,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output entry_t            rd_data_o
);

  entry_t mem [MAX_TASKS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- dv/tb_delayed_task_timer_table_core.sv -----
// testbench for delayed_task_timer_table_core: directed and random schedule/tick traffic
// checked against an in-bench timer table predictor; depends on dtt_pkg and the core rtl
`timescale 1ns / 1ps

module tb_delayed_task_timer_table_core;
  import dtt_pkg::*;

  localparam int   DRAIN_CYCLES = 300;

  typedef struct {
    kind_e             kind;
    logic [TASK_W-1:0] task_ref;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } timer_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               action_i    = ACT_SCHEDULE;
  logic [TASK_W-1:0]  task_id_i   = '0;
  logic [DELAY_W-1:0] delay_ms_i  = '0;
  logic [TIME_W-1:0]  now_ms_i    = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         kind_o;
  logic [TASK_W-1:0]  fired_task_o;
  logic [SLOT_W-1:0]  slot_o;
  logic               last_o;

  // predictor copy of the table
  logic [TIME_W-1:0]  due_tbl   [MAX_TASKS];
  logic [TASK_W-1:0]  task_tbl  [MAX_TASKS];
  logic               fired_tbl [MAX_TASKS];
  int unsigned        used_cnt = 0;

  timer_result_t      pending_results[$];
  int unsigned        mismatch_cnt = 0;
  bit                 idle_en = 1'b1;
  logic [TIME_W-1:0]  base_ms;

  delayed_task_timer_table_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .task_id_i    (task_id_i),
    .delay_ms_i   (delay_ms_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .fired_task_o (fired_task_o),
    .slot_o       (slot_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_delayed_task_timer_table_core NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic void predict_timer(input logic act, input logic [TASK_W-1:0] id,
                                        input logic [DELAY_W-1:0] dly,
                                        input logic [TIME_W-1:0] now);
    logic [TIME_W:0] sum;
    timer_result_t   r;
    timer_result_t   fired_now[$];
    if (act == ACT_SCHEDULE) begin
      if (used_cnt >= MAX_TASKS) begin
        r = '{KIND_FULL, '0, '0, 1'b1};
      end else begin
        sum = {1'b0, now} + {2'b00, dly};
        due_tbl[used_cnt]   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        task_tbl[used_cnt]  = id;
        fired_tbl[used_cnt] = 1'b0;
        r = '{KIND_SCHEDULED, id, SLOT_W'(used_cnt), 1'b1};
        used_cnt++;
      end
      pending_results.push_back(r);
    end else begin
      for (int i = 0; i < used_cnt; i++) begin
        if (!fired_tbl[i] && due_tbl[i] < now) begin
          fired_now.push_back('{KIND_FIRED, task_tbl[i], SLOT_W'(i), 1'b0});
          fired_tbl[i] = 1'b1;
        end
      end
      if (fired_now.size() == 0) begin
        pending_results.push_back('{KIND_IDLE, '0, '0, 1'b1});
      end else begin
        fired_now[fired_now.size()-1].last = 1'b1;
        foreach (fired_now[k]) pending_results.push_back(fired_now[k]);
      end
    end
  endfunction

  task automatic send_item(input logic act, input logic [TASK_W-1:0] id,
                           input logic [DELAY_W-1:0] dly, input logic [TIME_W-1:0] now);
    while (idle_en && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    task_id_i  <= id;
    delay_ms_i <= dly;
    now_ms_i   <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_timer(act, id, dly, now);
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] now);
    send_item(ACT_TICK, TASK_W'($urandom), DELAY_W'($urandom), now);
  endtask

  // output side: random stall and compare
  always @(posedge clk_i) begin
    out_stall_i <= idle_en ? ($urandom_range(0, 99) < 26) : 1'b0;
  end

  always @(posedge clk_i) begin
    timer_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction kind %0d task %h slot %0d",
                                  kind_o, fired_task_o, slot_o));
      end else begin
        exp_r = pending_results.pop_front();
        if (kind_o !== exp_r.kind)
          report_mismatch($sformatf("kind %0d, expected %s", kind_o, exp_r.kind.name()));
        if (fired_task_o !== exp_r.task_ref)
          report_mismatch($sformatf("fired_task %h, expected %h", fired_task_o,
                                    exp_r.task_ref));
        if (slot_o !== exp_r.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", slot_o, exp_r.slot));
        if (last_o !== exp_r.last)
          report_mismatch($sformatf("last %b, expected %b", last_o, exp_r.last));
      end
    end
  end

  task automatic test_schedule_edges();
    send_item(ACT_SCHEDULE, 16'h0000, 31'd0, 32'd0);
    send_item(ACT_SCHEDULE, 16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_SCHEDULE, 16'h1234, 31'd5, 32'd100);
    send_item(ACT_SCHEDULE, 16'hA5A5, 31'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_SCHEDULE, 16'h5A5A, 31'h7FFF_FFFF, 32'h8000_0001);
    send_item(ACT_SCHEDULE, 16'h0001, 31'h4000_0000, 32'h3FFF_FFFF);
  endtask

  task automatic test_tick_edges();
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd105);
    send_tick(32'd106);
    send_tick(32'd106);
    send_tick(32'h8000_0000);
    send_tick(32'hFFFF_FFFF);
  endtask

  task automatic test_multi_fire();
    send_item(ACT_SCHEDULE, 16'h0003, 31'd1, 32'd200);
    send_item(ACT_SCHEDULE, 16'h0004, 31'd0, 32'd150);
    send_item(ACT_SCHEDULE, 16'h0005, 31'd2, 32'd199);
    send_tick(32'd300);
    send_tick(32'd300);
  endtask

  task automatic test_random_traffic(input int n);
    logic [DELAY_W-1:0] dly;
    logic [TIME_W-1:0]  now;
    int                 pick;
    base_ms = TIME_W'($urandom_range(1000, 5000));
    for (int k = 0; k < n; k++) begin
      idle_en <= !(k >= n / 3 && k < n / 3 + 60);
      pick = $urandom_range(0, 99);
      if (used_cnt < MAX_TASKS && pick < 35) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) dly = DELAY_W'($urandom_range(0, 300));
        else if (pick < 85) dly = DELAY_W'($urandom);
        else dly = 31'h7FFF_FFFF - DELAY_W'($urandom_range(0, 3));
        now = ($urandom_range(0, 99) < 10) ? TIME_W'($urandom) : base_ms;
        send_item(ACT_SCHEDULE, TASK_W'($urandom), dly, now);
      end else begin
        base_ms = base_ms + TIME_W'($urandom_range(0, 120));
        now = ($urandom_range(0, 99) < 5) ? TIME_W'($urandom) : base_ms;
        send_tick(now);
      end
    end
    idle_en <= 1'b1;
  endtask

  task automatic test_full_table();
    while (used_cnt < MAX_TASKS)
      send_item(ACT_SCHEDULE, TASK_W'($urandom), DELAY_W'($urandom_range(0, 50)), base_ms);
    repeat (3) send_item(ACT_SCHEDULE, TASK_W'($urandom), DELAY_W'($urandom), base_ms);
    send_tick(base_ms + 32'd1000);
    send_tick(32'hFFFF_FFFF);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_schedule_edges();
    test_tick_edges();
    test_multi_fire();
    test_random_traffic(230);
    test_full_table();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_delayed_task_timer_table_core OK");
    end else begin
      $display("tb_delayed_task_timer_table_core NOT OK");
    end
    $finish;
  end

endmodule

// ----- delayed_task_timer_table_core.f -----
rtl/core/dtt_pkg.sv
rtl/core/dtt_alu.sv
rtl/core/dtt_table.sv
rtl/core/delayed_task_timer_table_core.sv
dv/tb_delayed_task_timer_table_core.sv
